@@ rtl/scs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the source comment stripper
// no dependencies; imported by every module of the block

package scs_pkg;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // queue between classifier and output side, power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // results caused by one input byte: one byte, or two when a held slash goes out first
   typedef struct packed {
      logic       two;
      logic [7:0] second_byte;
      logic [7:0] first_byte;
   } pair_type;

endpackage

@@ rtl/scs_front.sv @@
`timescale 1ns / 1ps
// front end: accepts text bytes, runs the scan mode machine, pushes kept bytes
// depends on scs_pkg

module scs_front import scs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,   // final_byte
   input  logic       q_full,
   output logic       q_push,
   output pair_type   q_data
);

   typedef enum logic [5:0] {
      M_NORMAL = 6'b000001,
      M_QUOTE  = 6'b000010,
      M_QESC   = 6'b000100,
      M_BLOCK  = 6'b001000,
      M_BSTAR  = 6'b010000,
      M_LINE   = 6'b100000
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       quote_single_ff, quote_single_in;
   logic       slash_held_ff, slash_held_in;

   logic       accept;
   logic       emit_slash;
   logic       emit_byte;
   logic [7:0] b;
   logic       fin;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign fin        = req_tlast;

   always_comb begin
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      slash_held_in   = slash_held_ff;
      emit_slash      = 1'b0;
      emit_byte       = 1'b0;
      case (mode_ff)
         M_QUOTE: begin
            emit_byte = 1'b1;
            if (b == CH_BSLASH) begin
               mode_in = M_QESC;
            end else if (b == (quote_single_ff ? CH_SQUOTE : CH_DQUOTE)) begin
               mode_in = M_NORMAL;
            end
         end
         M_QESC: begin
            emit_byte = 1'b1;
            mode_in   = M_QUOTE;
         end
         M_BLOCK: begin
            if (fin) begin
               emit_byte = 1'b1;
            end else if (b == CH_STAR) begin
               mode_in = M_BSTAR;
            end
         end
         M_BSTAR: begin
            if (b == CH_SLASH) begin
               mode_in = M_NORMAL;
            end else if (fin) begin
               emit_byte = 1'b1;
            end else if (b != CH_STAR) begin
               mode_in = M_BLOCK;
            end
         end
         M_LINE: begin
            if (b == CH_NL) begin
               emit_byte = 1'b1;
               mode_in   = M_NORMAL;
            end
         end
         default: begin
            // normal text, also any code outside the one-hot set
            mode_in       = M_NORMAL;
            slash_held_in = 1'b0;
            if (slash_held_ff && b == CH_STAR) begin
               mode_in = M_BLOCK;
            end else if (slash_held_ff && b == CH_SLASH) begin
               mode_in = M_LINE;
            end else begin
               emit_slash = slash_held_ff;
               if (b == CH_SLASH && !fin) begin
                  slash_held_in = 1'b1;
               end else begin
                  emit_byte = 1'b1;
                  if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                     quote_single_in = (b == CH_SQUOTE);
                     mode_in         = M_QUOTE;
                  end
               end
            end
         end
      endcase
      // end of text brings everything back to reset
      if (fin) begin
         mode_in         = M_NORMAL;
         quote_single_in = 1'b0;
         slash_held_in   = 1'b0;
      end
   end

   assign q_push             = accept && (emit_slash || emit_byte);
   assign q_data.two         = emit_slash && emit_byte;
   assign q_data.first_byte  = emit_slash ? CH_SLASH : b;
   assign q_data.second_byte = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= M_NORMAL;
         quote_single_ff <= 1'b0;
         slash_held_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         quote_single_ff <= quote_single_in;
         slash_held_ff   <= slash_held_in;
      end
   end

endmodule

@@ rtl/scs_queue.sv @@
`timescale 1ns / 1ps
// small fifo of result pairs between the front end and the output side
// depends on scs_pkg

module scs_queue import scs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output pair_type pop_data
);

   pair_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]       count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/scs_back.sv @@
`timescale 1ns / 1ps
// output side: splits queued pairs into single result transactions
// depends on scs_pkg

module scs_back import scs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  pair_type   q_data,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tlast    // run_end
);

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       pending_ff;
   logic [7:0] pend_byte_ff;
   logic       fire;
   logic       load_slot;

   assign fire       = out_valid_ff && rsp_tready;
   assign load_slot  = !out_valid_ff || fire;
   assign q_pop      = load_slot && !pending_ff && q_not_empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (load_slot) begin
         if (pending_ff) begin
            out_byte_ff <= pend_byte_ff;
            out_last_ff <= 1'b1;
         end else begin
            out_byte_ff  <= q_data.first_byte;
            out_last_ff  <= !q_data.two;
            pend_byte_ff <= q_data.second_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else if (load_slot) begin
         if (pending_ff) begin
            out_valid_ff <= 1'b1;
            pending_ff   <= 1'b0;
         end else begin
            out_valid_ff <= q_not_empty;
            pending_ff   <= q_not_empty && q_data.two;
         end
      end
   end

   a_pending_has_output: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> out_valid_ff)
      else $error("second byte pending with no first byte shown");

   a_not_last_means_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> pending_ff)
      else $error("non-final result without a following byte");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (fire && pending_ff) |=> (rsp_tvalid && rsp_tlast))
      else $error("second byte of a pair did not follow as last");

endmodule

@@ rtl/source_comment_stripper_top.sv @@
`timescale 1ns / 1ps
// top level of the source comment stripper: front end, pair queue, output side
// depends on scs_pkg, scs_front, scs_queue, scs_back
//
//   channel  direction  tdata             tuser  tlast
//   req      in         in_byte[7:0]      -      final_byte
//   rsp      out        out_byte[7:0]     -      run_end
//
// one input byte accepted per cycle while the pair queue has room
// a byte that yields two results holds the output side until its second result is loaded
// each result passes through the queue and the output register
// synchronous active-high reset returns the scan mode to normal text
// either side may stall; the queue decouples them

module source_comment_stripper_top import scs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tlast    // run_end
);

   logic     q_full;
   logic     q_push;
   pair_type q_push_data;
   logic     q_pop;
   logic     q_not_empty;
   pair_type q_pop_data;

   scs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   scs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   scs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ tb/sv/source_comment_stripper_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for source_comment_stripper_top: feeds source text, checks kept text
// depends on scs_pkg and the block rtl; a local scanner predicts every kept byte

module source_comment_stripper_top_tb import scs_pkg::*;;

   localparam int TEXT_ITEMS  = 950;
   localparam int LONG_HOLD   = 100;
   localparam int TAIL_CYCLES = 8;

   typedef enum logic [2:0] {
      SCAN_TEXT, SCAN_QUOTE, SCAN_QESC, SCAN_BLOCK, SCAN_BSTAR, SCAN_LINE
   } scan_type;

   typedef struct {
      logic [7:0] text;
      logic       last;
      bit         drain;   // hold back until all kept text has come out
      bit         burst;   // no idle cycles before this transaction
   } src_byte_type;

   typedef struct {
      logic [7:0] text;
      logic       last;
   } kept_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   src_byte_type  src_bytes [$];
   kept_byte_type kept_text [$];
   logic [7:0]    text_buf [$];

   scan_type scan_state   = SCAN_TEXT;
   logic  in_single_quote = 1'b0;
   logic  slash_pend      = 1'b0;

   int src_total;
   int src_taken;
   int kept_seen;
   int errors;
   int gap_left;
   bit gap_drawn;
   int stall_left;
   int hold_left;
   int hold_mark = -1;

   source_comment_stripper_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scanner: kept bytes caused by one input byte
   task automatic strip_byte(input logic [7:0] b, input logic fin);
      logic [7:0]    outs [2];
      int            n;
      bit            opened;
      scan_type      m;
      kept_byte_type k;
      n = 0;
      opened = 1'b0;
      m = scan_state;
      case (m)
         SCAN_TEXT: begin
            if (slash_pend) begin
               slash_pend = 1'b0;
               if (b == CH_STAR) begin
                  m = SCAN_BLOCK;
                  opened = 1'b1;
               end else if (b == CH_SLASH) begin
                  m = SCAN_LINE;
                  opened = 1'b1;
               end else begin
                  outs[n] = CH_SLASH;
                  n++;
               end
            end
            if (!opened) begin
               if (b == CH_SLASH && !fin) begin
                  slash_pend = 1'b1;
               end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  outs[n] = b;
                  n++;
                  in_single_quote = (b == CH_SQUOTE);
                  m = SCAN_QUOTE;
               end else begin
                  outs[n] = b;
                  n++;
               end
            end
         end
         SCAN_QUOTE: begin
            outs[n] = b;
            n++;
            if (b == CH_BSLASH) m = SCAN_QESC;
            else if (b == (in_single_quote ? CH_SQUOTE : CH_DQUOTE)) m = SCAN_TEXT;
         end
         SCAN_QESC: begin
            outs[n] = b;
            n++;
            m = SCAN_QUOTE;
         end
         SCAN_BLOCK: begin
            if (fin) begin
               outs[n] = b;
               n++;
            end else if (b == CH_STAR) begin
               m = SCAN_BSTAR;
            end
         end
         SCAN_BSTAR: begin
            if (b == CH_SLASH) begin
               m = SCAN_TEXT;
            end else if (fin) begin
               outs[n] = b;
               n++;
            end else if (b != CH_STAR) begin
               m = SCAN_BLOCK;
            end
         end
         default: begin
            if (b == CH_NL) begin
               outs[n] = b;
               n++;
               m = SCAN_TEXT;
            end
         end
      endcase
      scan_state = m;
      for (int i = 0; i < n; i++) begin
         k.text = outs[i];
         k.last = (i == n - 1);
         kept_text.push_back(k);
      end
      if (fin) begin
         scan_state = SCAN_TEXT;
         in_single_quote = 1'b0;
         slash_pend = 1'b0;
      end
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 11))
         0:       return CH_STAR;
         1:       return CH_SLASH;
         2:       return CH_DQUOTE;
         3:       return CH_SQUOTE;
         4:       return CH_BSLASH;
         5:       return CH_NL;
         6:       return 8'h20;
         7:       return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // one lexical piece of c-like text
   task automatic add_token();
      int         n;
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         end
         2: begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(pick_char());
         end
         3: begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_SLASH);
            n = $urandom_range(0, 5);
            repeat (n) begin
               c = pick_char();
               text_buf.push_back(c == CH_NL ? 8'h78 : c);
            end
            text_buf.push_back(CH_NL);
         end
         4: begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
            n = $urandom_range(0, 6);
            repeat (n) text_buf.push_back(pick_char());
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
         end
         5, 6: begin
            c = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_buf.push_back(c);
            n = $urandom_range(0, 5);
            repeat (n) begin
               text_buf.push_back(pick_char());
               if (text_buf[$] == CH_BSLASH) text_buf.push_back(pick_char());
            end
            text_buf.push_back(c);
         end
         7: text_buf.push_back(CH_NL);
         default: text_buf.push_back(8'($urandom));
      endcase
   endtask

   task automatic queue_text(input bit burst, input bit drain);
      src_byte_type s;
      foreach (text_buf[i]) begin
         s.text  = text_buf[i];
         s.last  = (i == text_buf.size() - 1);
         s.drain = drain && (i == 0);
         s.burst = burst;
         src_bytes.push_back(s);
      end
      text_buf.delete();
   endtask

   // sender
   always @(posedge clock) begin : drive
      bit           fire;
      bit           vld;
      src_byte_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         fire = req_tvalid && req_tready;
         vld = req_tvalid;
         if (fire) begin
            strip_byte(req_tdata, req_tlast);
            src_taken++;
         end
         if (!req_tvalid || fire) begin
            vld = 1'b0;
            if (src_bytes.size() > 0 && !(src_bytes[0].drain && kept_text.size() > 0)) begin
               if (!gap_drawn) begin
                  gap_left = src_bytes[0].burst ? 0 : $urandom_range(0, 7);
                  gap_drawn = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  s = src_bytes.pop_front();
                  req_tdata <= s.text;
                  req_tlast <= s.last;
                  vld = 1'b1;
                  gap_drawn = 1'b0;
               end
            end
         end
         req_tvalid <= vld;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch
      bit            rdy;
      kept_byte_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            kept_seen++;
            if (kept_text.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction: expected none, actual byte %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               e = kept_text.pop_front();
               if (rsp_tdata !== e.text) begin
                  errors++;
                  $display("%0t: out_byte: expected %h, actual %h", $time, e.text, rsp_tdata);
               end
               if (rsp_tlast !== e.last) begin
                  errors++;
                  $display("%0t: run_end: expected %b, actual %b", $time, e.last, rsp_tlast);
               end
            end
            stall_left = (kept_seen % 300 < 80) ? 0 : $urandom_range(0, 7);
         end
         // long back-pressure so the block fills and stalls its input
         if (hold_left == 0 && kept_seen % 400 == 200 && kept_seen != hold_mark) begin
            hold_left = LONG_HOLD;
            hold_mark = kept_seen;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   initial begin : run
      int goal;
      int len;
      // slash then nul, quoted markers with an escape, line comment closed by the last newline
      text_buf.push_back(CH_SLASH);
      text_buf.push_back(8'h00);
      add_str("\"/*\\\"\"//\n");
      queue_text(1'b0, 1'b0);
      // single quotes around a double quote, block comment with extra stars closed on last
      add_str("'\"'/***/");
      queue_text(1'b0, 1'b0);
      // lone slash as last byte
      add_str("/");
      queue_text(1'b0, 1'b0);
      // comment opener ends the text
      add_str("/*");
      queue_text(1'b0, 1'b0);
      // block comment left open, last byte 0xff comes out
      add_str("/*");
      text_buf.push_back(8'hFF);
      queue_text(1'b0, 1'b0);
      // line comment left open
      add_str("//a");
      queue_text(1'b0, 1'b0);

      goal = src_bytes.size() + TEXT_ITEMS;
      for (int t = 0; src_bytes.size() < goal; t++) begin
         len = $urandom_range(1, 40);
         if ($urandom_range(0, 7) == 0) begin
            repeat (len) text_buf.push_back(8'($urandom));
         end else begin
            while (text_buf.size() < len) add_token();
            // some texts stop in the middle of a comment or string
            if ($urandom_range(0, 2) == 0) begin
               while (text_buf.size() > len) void'(text_buf.pop_back());
            end
         end
         queue_text(t % 5 == 3, t == 4 || $urandom_range(0, 15) == 0);
      end
      src_total = src_bytes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (src_taken < src_total || kept_text.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("source_comment_stripper_top: match");
      end else begin
         $display("source_comment_stripper_top: mismatch");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("source_comment_stripper_top: mismatch");
      $finish;
   end

endmodule

@@ source_comment_stripper_top.f @@
rtl/scs_pkg.sv
rtl/scs_front.sv
rtl/scs_queue.sv
rtl/scs_back.sv
rtl/source_comment_stripper_top.sv
tb/sv/source_comment_stripper_top_tb.sv
